### rtl/tscf_pkg.sv
package tscf_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // register map of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_NONBLANK  = 3'd0,
    REG_SHOW_ENDS        = 3'd1,
    REG_NUMBER_ALL       = 3'd2,
    REG_SQUEEZE_BLANK    = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } reg_index_t;

  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NL        = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_I         = 8'h49;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_DEL       = 8'd127;
  localparam logic [7:0] CARET_OFFSET = 8'd64;
  localparam logic [7:0] CTRL_LAST    = 8'd31;

  // what the back end has to emit for one accepted byte
  typedef struct packed {
    logic       number;      // line number and tab first
    logic       pad;         // blank field and tab first
    logic       dollar;      // '$' before the byte
    logic       caret;       // '^' before the byte
    logic [7:0] final_byte;  // last byte of the run
  } desc_t;

endpackage

### rtl/tscf_if.sv
interface tscf_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;
  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tscf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface tscf_cfg_if import tscf_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tscf_front.sv
module tscf_front import tscf_pkg::*; #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  tscf_item_if.sink                  item,
  tscf_cfg_if.sink                   cfg,
  input  logic                       q_full,
  output logic                       push,
  output desc_t                      desc,
  output logic [4*NUMBER_DIGITS-1:0] digits
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

  logic number_nonblank, show_ends, number_all;
  logic squeeze_blank, show_tabs, show_nonprinting;

  logic [7:0]       prev_byte;
  logic             squeeze_seen;
  logic [BCD_W-1:0] line_bcd;

  logic             accept, cur_nl, prev_nl, sq_cur, sq_next, drop, numbered;
  logic             all_nines, carry;
  logic [7:0]       c;
  logic [BCD_W-1:0] bcd_cur, bcd_inc;

  assign item.ready = !q_full;
  assign cfg.ready  = 1'b1;

  always_comb begin
    accept  = item.valid && item.ready;
    c       = item.data_byte;
    cur_nl  = (c == CH_NL);
    // start of file acts as if the previous byte were a newline
    prev_nl = item.start_of_file || (prev_byte == CH_NL);
    sq_cur  = !item.start_of_file && squeeze_seen;
    bcd_cur = item.start_of_file ? BCD_ONE : line_bcd;

    drop    = squeeze_blank && cur_nl && prev_nl && sq_cur;
    if (squeeze_blank) begin
      sq_next = cur_nl && prev_nl;
    end else begin
      sq_next = sq_cur;
    end

    if (number_nonblank) begin
      numbered = prev_nl && !cur_nl;
    end else begin
      numbered = number_all && prev_nl;
    end
    numbered = numbered && !drop;

    // BCD increment, saturating at all nines
    all_nines = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (bcd_cur[4*i +: 4] != 4'd9) all_nines = 1'b0;
    end
    bcd_inc = bcd_cur;
    carry   = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (bcd_cur[4*i +: 4] < 4'd9) begin
          bcd_inc[4*i +: 4] = bcd_cur[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end else begin
          bcd_inc[4*i +: 4] = 4'd0;
        end
      end
    end
    if (all_nines) bcd_inc = bcd_cur;

    desc.number     = numbered;
    desc.pad        = show_ends && cur_nl && number_nonblank && prev_nl;
    desc.dollar     = show_ends && cur_nl;
    desc.caret      = 1'b0;
    desc.final_byte = c;
    if (show_tabs && c == CH_TAB) begin
      desc.caret      = 1'b1;
      desc.final_byte = CH_I;
    end else if (show_nonprinting) begin
      if (c <= CTRL_LAST && c != CH_TAB && c != CH_NL) begin
        desc.caret      = 1'b1;
        desc.final_byte = c + CARET_OFFSET;
      end else if (c == CH_DEL) begin
        desc.caret      = 1'b1;
        desc.final_byte = CH_DEL - CARET_OFFSET;
      end
    end

    push   = accept && !drop;
    digits = bcd_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_nonblank  <= 1'b0;
      show_ends        <= 1'b0;
      number_all       <= 1'b0;
      squeeze_blank    <= 1'b0;
      show_tabs        <= 1'b0;
      show_nonprinting <= 1'b0;
      prev_byte        <= CH_NL;
      squeeze_seen     <= 1'b0;
      line_bcd         <= BCD_ONE;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_NUMBER_NONBLANK:  number_nonblank  <= cfg.data[0];
          REG_SHOW_ENDS:        show_ends        <= cfg.data[0];
          REG_NUMBER_ALL:       number_all       <= cfg.data[0];
          REG_SQUEEZE_BLANK:    squeeze_blank    <= cfg.data[0];
          REG_SHOW_TABS:        show_tabs        <= cfg.data[0];
          REG_SHOW_NONPRINTING: show_nonprinting <= cfg.data[0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_byte    <= c;
        squeeze_seen <= sq_next;
        line_bcd     <= numbered ? bcd_inc : bcd_cur;
      end
    end
  end

endmodule

### rtl/tscf_queue.sv
module tscf_queue import tscf_pkg::*; #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  desc_t                      push_desc,
  input  logic [4*NUMBER_DIGITS-1:0] push_digits,
  output logic                       full,
  input  logic                       pop,
  output logic                       head_valid,
  output desc_t                      head_desc,
  output logic [4*NUMBER_DIGITS-1:0] head_digits
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            q_desc [DEPTH];
  logic [BCD_W-1:0] q_dig  [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full        = (count == CNT_W'(DEPTH));
  assign head_valid  = (count != '0);
  assign head_desc   = q_desc[rd_ptr];
  assign head_digits = q_dig[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_desc[wr_ptr] <= push_desc;
      q_dig[wr_ptr]  <= push_digits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

### rtl/tscf_back.sv
module tscf_back import tscf_pkg::*; #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  desc_t                      head_desc,
  input  logic [4*NUMBER_DIGITS-1:0] head_digits,
  output logic                       pop,
  tscf_result_if.source              result
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;
  localparam int POS_W = $clog2(NUMBER_DIGITS + 1);
  localparam logic [POS_W-1:0] TAB_POS    = POS_W'(NUMBER_DIGITS);
  localparam logic [POS_W-1:0] LAST_DIGIT = POS_W'(NUMBER_DIGITS - 1);

  typedef enum logic [1:0] {PH_PREFIX, PH_DOLLAR, PH_CARET, PH_FINAL} phase_t;

  phase_t           phase, cur_phase, phase_next, after_prefix;
  logic             mid, seen_nz, seen_next, load, done;
  logic [POS_W-1:0] pos, cur_pos, pos_next;
  logic [BCD_W-1:0] shift_dig, cur_dig, dig_next;
  logic [3:0]       top;
  logic [7:0]       byte_next;

  always_comb begin
    load = head_valid && (!result.valid || result.ready);

    if (head_desc.dollar) begin
      after_prefix = PH_DOLLAR;
    end else if (head_desc.caret) begin
      after_prefix = PH_CARET;
    end else begin
      after_prefix = PH_FINAL;
    end

    if (mid) begin
      cur_phase = phase;
    end else if (head_desc.number || head_desc.pad) begin
      cur_phase = PH_PREFIX;
    end else begin
      cur_phase = after_prefix;
    end
    cur_pos = mid ? pos : '0;
    cur_dig = mid ? shift_dig : head_digits;
    top     = cur_dig[BCD_W-1 -: 4];

    byte_next  = head_desc.final_byte;
    phase_next = cur_phase;
    pos_next   = cur_pos;
    seen_next  = seen_nz;
    dig_next   = cur_dig;
    done       = 1'b0;

    unique case (cur_phase)
      PH_PREFIX: begin
        if (cur_pos == TAB_POS) begin
          byte_next  = CH_TAB;
          phase_next = after_prefix;
        end else begin
          // digits go out most significant first; leading zeros blank
          if (head_desc.pad) begin
            byte_next = CH_SPACE;
          end else if (top != 4'd0 || seen_nz || cur_pos == LAST_DIGIT) begin
            byte_next = CH_ZERO + {4'd0, top};
            seen_next = 1'b1;
          end else begin
            byte_next = CH_SPACE;
          end
          pos_next = cur_pos + POS_W'(1);
          dig_next = cur_dig << 4;
        end
      end
      PH_DOLLAR: begin
        byte_next  = CH_DOLLAR;
        phase_next = head_desc.caret ? PH_CARET : PH_FINAL;
      end
      PH_CARET: begin
        byte_next  = CH_CARET;
        phase_next = PH_FINAL;
      end
      PH_FINAL: begin
        byte_next = head_desc.final_byte;
        done      = 1'b1;
      end
      default: ;
    endcase

    pop = load && done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid          <= 1'b0;
      phase        <= PH_PREFIX;
      pos          <= '0;
      seen_nz      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (load) begin
        result.valid       <= 1'b1;
        result.out_byte    <= byte_next;
        result.last_of_run <= done;
        if (done) begin
          mid     <= 1'b0;
          pos     <= '0;
          seen_nz <= 1'b0;
        end else begin
          mid       <= 1'b1;
          phase     <= phase_next;
          pos       <= pos_next;
          seen_nz   <= seen_next;
          shift_dig <= dig_next;
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> result.valid && result.last_of_run)
    else $error("run finished without last byte flag");
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    mid |-> head_valid)
    else $error("queue head lost in the middle of a run");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.out_byte) &&
      $stable(result.last_of_run))
    else $error("output byte changed while stalled");
`endif

endmodule

### rtl/text_stream_cat_filter.sv
// channel  | role   | transaction
// ---------+--------+--------------------------------------------------
// item     | sink   | data_byte, start_of_file: one byte of input text
// result   | source | out_byte, last_of_run: one byte of output text
// cfg      | sink   | index, data: register write, bit 0 of data used
//
// Each input byte is taken while the queue has room; the back end puts out one
// result byte per cycle while the output is not stalled, so an item yields 1
// to NUMBER_DIGITS+3 bytes through the single output register. A squeezed
// line is dropped at the front and yields nothing at the back.
// A two-entry queue between front and back keeps input flowing while a run
// is still being emitted; the front stalls only when both entries are taken.
// The first result byte of an item is registered in the queue and then in the
// output register.
// Synchronous reset: counter to 1, previous byte to newline, no clearing pass.
module text_stream_cat_filter import tscf_pkg::*; #(
  parameter int NUMBER_DIGITS = 6
) (
  input  logic          clk,
  input  logic          rst,
  tscf_item_if.sink     item,
  tscf_result_if.source result,
  tscf_cfg_if.sink      cfg
);

  localparam int BCD_W = 4 * NUMBER_DIGITS;

  // front to queue
  logic             push, q_full;
  desc_t            push_desc;
  logic [BCD_W-1:0] push_digits;

  // queue to back
  logic             head_valid, pop;
  desc_t            head_desc;
  logic [BCD_W-1:0] head_digits;

  // front: holds config, previous byte, squeeze flag and line counter;
  // turns each byte into a descriptor of its output run (or drops it)
  tscf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .desc   (push_desc),
    .digits (push_digits)
  );

  // decoupling queue; carries the counter snapshot with each descriptor
  tscf_queue #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_desc   (push_desc),
    .push_digits (push_digits),
    .full        (q_full),
    .pop         (pop),
    .head_valid  (head_valid),
    .head_desc   (head_desc),
    .head_digits (head_digits)
  );

  // back: walks prefix, '$', '^' and final byte into the output register
  tscf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_desc   (head_desc),
    .head_digits (head_digits),
    .pop         (pop),
    .result      (result)
  );

endmodule
